@@ design/icmpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP decode package
// Shared constants, types and the ones-complement add used by the ICMP
// message decoder and checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpd_pkg;

  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int HEADER_BYTES      = 8;
  localparam int PAYLOAD_KEEP      = 8;

  localparam logic [7:0] RESET_MSG_TYPE = 8'd8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] identifier;
    logic [15:0] sequence_res;
  } header_t;

  typedef struct packed {
    status_t      status;
    header_t      header;
    logic [63:0]  payload;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] t);
    logic [16:0] v;
    logic [16:0] w;
    v = {1'b0, s} + {1'b0, t};
    w = {1'b0, v[15:0]} + {16'd0, v[16]};
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

@@ design/icmpd_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP decode byte accumulator
// Holds the per-message state, captures the header and payload fields, keeps
// the ones-complement sum and forms the result on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpd_accum #(
  parameter int MAX_MESSAGE_BYTES = icmpd_pkg::MAX_MESSAGE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   res_load,
  output icmpd_pkg::result_t     res
);

  localparam int CntW = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_MESSAGE_BYTES);
  localparam logic [CntW-1:0] HdrCnt  = CntW'(icmpd_pkg::HEADER_BYTES);
  localparam logic [CntW-1:0] PayEnd  =
    CntW'(icmpd_pkg::HEADER_BYTES + icmpd_pkg::PAYLOAD_KEEP);

  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [15:0]         sum_r, sum_nxt;
  logic [7:0]          odd_r, odd_nxt;
  logic [15:0]         rcv_r, rcv_nxt;
  icmpd_pkg::header_t  hdr_r, hdr_nxt;
  logic [63:0]         pay_r, pay_nxt;
  icmpd_pkg::header_t  chdr_r, chdr_nxt;
  logic [63:0]         cpay_r, cpay_nxt;

  logic [15:0]         sum_base;
  logic [15:0]         sum_fin;
  logic [2:0]          lane;
  icmpd_pkg::status_t  status;

  always_comb begin
    sum_base = (cnt_r == '0) ? 16'd0 : sum_r;
    odd_nxt  = (cnt_r == '0) ? 8'd0 : odd_r;
    rcv_nxt  = (cnt_r == '0) ? 16'd0 : rcv_r;
    pay_nxt  = (cnt_r == '0) ? 64'd0 : pay_r;
    hdr_nxt  = hdr_r;
    sum_nxt  = sum_base;
    cnt_nxt  = cnt_r;
    chdr_nxt = chdr_r;
    cpay_nxt = cpay_r;
    lane     = 3'(cnt_r - HdrCnt);
    status   = icmpd_pkg::ST_OK;
    sum_fin  = sum_base;

    if (cnt_r < MaxCnt) begin
      if (cnt_r < HdrCnt) begin
        unique case (cnt_r[2:0])
          3'd0: hdr_nxt.msg_type = data_byte;
          3'd1: hdr_nxt.msg_code = data_byte;
          3'd2: rcv_nxt[15:8] = data_byte;
          3'd3: rcv_nxt[7:0] = data_byte;
          3'd4: hdr_nxt.identifier[15:8] = data_byte;
          3'd5: hdr_nxt.identifier[7:0] = data_byte;
          3'd6: hdr_nxt.sequence_res[15:8] = data_byte;
          3'd7: hdr_nxt.sequence_res[7:0] = data_byte;
        endcase
      end else if (cnt_r < PayEnd) begin
        pay_nxt[{lane, 3'b000} +: 8] = data_byte;
      end
      if (cnt_r != CntW'(2) && cnt_r != CntW'(3)) begin
        if (!cnt_r[0]) begin
          odd_nxt = data_byte;
        end else begin
          sum_nxt = icmpd_pkg::oc_add(sum_base, {odd_nxt, data_byte});
        end
      end
      cnt_nxt = cnt_r + CntW'(1);
    end else begin
      cnt_nxt = MaxCnt + CntW'(1);
    end

    if (cnt_nxt[0]) begin
      sum_fin = icmpd_pkg::oc_add(sum_nxt, {odd_nxt, 8'd0});
    end else begin
      sum_fin = sum_nxt;
    end

    if (cnt_nxt < HdrCnt) begin
      status = icmpd_pkg::ST_TOO_SHORT;
    end else if (cnt_nxt > MaxCnt) begin
      status = icmpd_pkg::ST_TOO_LONG;
    end else begin
      chdr_nxt = hdr_nxt;
      cpay_nxt = pay_nxt;
      status   = (~sum_fin == rcv_nxt) ? icmpd_pkg::ST_OK : icmpd_pkg::ST_MISMATCH;
    end

    if (!last_byte) begin
      chdr_nxt = chdr_r;
      cpay_nxt = cpay_r;
    end else begin
      cnt_nxt = '0;
    end
  end

  assign res_load       = accept && last_byte;
  assign res.status     = status;
  assign res.header     = chdr_nxt;
  assign res.payload    = cpay_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      chdr_r <= '{msg_type: icmpd_pkg::RESET_MSG_TYPE, msg_code: 8'd0,
                  identifier: 16'd0, sequence_res: 16'd0};
      cpay_r <= 64'd0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      chdr_r <= chdr_nxt;
      cpay_r <= cpay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= sum_nxt;
      odd_r <= odd_nxt;
      rcv_r <= rcv_nxt;
      hdr_r <= hdr_nxt;
      pay_r <= pay_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/icmpd_outreg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP decode result register
// Holds one result item and presents it on the output channel until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpd_outreg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire icmpd_pkg::result_t res,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output icmpd_pkg::result_t      out_res,
  output logic                    busy
);

  logic               valid_r, valid_nxt;
  icmpd_pkg::result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign busy      = valid_r && out_stall;

endmodule

`default_nettype wire

@@ design/icmp_message_decode_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP message decoder and checksum checker
// Parses an ICMP message byte by byte and checks its ones-complement sum.
// ----------------------------------------------------------------------------
// The input channel carries one message byte per item, with in_last_byte set
// on the final byte. The output channel carries one result item per message:
// a status, the committed type, code, identifier and sequence number, and the
// first eight payload bytes as a signed little-endian value.
// Bytes are taken one per cycle. The result item appears on the output in the
// cycle after the final byte is accepted, from a single result register.
// While a result waits under out_stall, ordinary bytes are still taken; only
// a final byte is held off until the waiting result has been taken, so the
// rate is one byte per cycle whenever results are taken promptly.
// Reset clears the byte count and the result register's valid flag, and sets
// the committed header to type 8 with all other fields zero.
// A too short or too long message reports the previously committed fields.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_message_decode_check #(
  parameter int MAX_MESSAGE_BYTES = icmpd_pkg::MAX_MESSAGE_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [7:0]              out_msg_type,
  output logic [7:0]              out_msg_code,
  output logic [15:0]             out_identifier,
  output logic [15:0]             out_sequence_res,
  output logic signed [63:0]      out_payload_value
);

  logic               accept;
  logic               res_load;
  logic               busy;
  icmpd_pkg::result_t res;
  icmpd_pkg::result_t out_res;

  assign in_stall = busy && in_last_byte;
  assign accept   = in_valid && !in_stall;

  icmpd_accum #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res_load  (res_load),
    .res       (res)
  );

  icmpd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .busy      (busy)
  );

  assign out_status        = out_res.status;
  assign out_msg_type      = out_res.header.msg_type;
  assign out_msg_code      = out_res.header.msg_code;
  assign out_identifier    = out_res.header.identifier;
  assign out_sequence_res  = out_res.header.sequence_res;
  assign out_payload_value = $signed(out_res.payload);

endmodule

`default_nettype wire

@@ design/icmpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP decode checker
// Port-level assertions on the decoder's handshakes and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_last_byte,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic [7:0]         out_msg_type,
  input wire logic [7:0]         out_msg_code,
  input wire logic [15:0]        out_identifier,
  input wire logic [15:0]        out_sequence_res,
  input wire logic signed [63:0] out_payload_value
);

  // A stalled result item stays valid and holds all its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_msg_type) && $stable(out_msg_code)
      && $stable(out_identifier) && $stable(out_sequence_res)
      && $stable(out_payload_value))
    else $error("stalled result item changed");

  // An accepted final byte yields a result item in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> out_valid)
    else $error("final byte gave no result item");

  // Bytes that are not final never cause a result item.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && !in_stall && in_last_byte) |=> !out_valid)
    else $error("result item without a final byte");

  // Only a final byte can be held off.
  a_stall_final_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_last_byte && out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind icmp_message_decode_check icmpd_checker u_icmpd_checker (.*);

`default_nettype wire

@@ verif/tb_icmp_message_decode_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP message decoder testbench
// Streams ICMP messages one byte per item into the decoder, mostly with a
// correct ones-complement checksum and some with a broken one, short or
// overlong. A local model of the decoder predicts each result item, which the
// output monitor checks field by field. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

module tb_icmp_message_decode_check;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CALM_ITEMS      = 300;
  localparam int BYTE_BUDGET     = 1600;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         pause;
  } byte_item_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_last_byte = 1'b0;
  logic               out_stall    = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [7:0]         out_msg_type;
  logic [7:0]         out_msg_code;
  logic [15:0]        out_identifier;
  logic [15:0]        out_sequence_res;
  logic signed [63:0] out_payload_value;

  byte_item_t          pending_bytes[$];
  icmpd_pkg::result_t  results_due[$];
  byte_item_t          next_byte;
  int                  errors      = 0;
  int                  send_gap    = 0;
  int                  stall_left  = 0;
  int                  idle_cycles = 0;

  logic [10:0]         msg_bytes;
  logic [15:0]         msg_sum;
  logic [7:0]          pair_high;
  logic [15:0]         msg_checksum;
  icmpd_pkg::header_t  hdr_capture;
  icmpd_pkg::header_t  hdr_commit;
  logic [63:0]         payload_capture;
  logic [63:0]         payload_commit;

  icmp_message_decode_check dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_msg_type     (out_msg_type),
    .out_msg_code     (out_msg_code),
    .out_identifier   (out_identifier),
    .out_sequence_res (out_sequence_res),
    .out_payload_value(out_payload_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + t[16];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("Mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [15:0]        s;
    icmpd_pkg::result_t r;
    if (msg_bytes == 0) begin
      msg_sum         = '0;
      pair_high       = '0;
      msg_checksum    = '0;
      hdr_capture     = '0;
      payload_capture = '0;
    end
    if (msg_bytes < icmpd_pkg::MAX_MESSAGE_BYTES) begin
      case (msg_bytes)
        0: hdr_capture.msg_type = b;
        1: hdr_capture.msg_code = b;
        2: msg_checksum = {b, 8'h00};
        3: msg_checksum[7:0] = b;
        4: hdr_capture.identifier[15:8] = b;
        5: hdr_capture.identifier[7:0] = b;
        6: hdr_capture.sequence_res[15:8] = b;
        7: hdr_capture.sequence_res[7:0] = b;
        default: begin
          if (msg_bytes < icmpd_pkg::HEADER_BYTES + icmpd_pkg::PAYLOAD_KEEP)
            payload_capture[(msg_bytes - icmpd_pkg::HEADER_BYTES) * 8 +: 8] = b;
        end
      endcase
      if (msg_bytes != 2 && msg_bytes != 3) begin
        if (!msg_bytes[0]) pair_high = b;
        else msg_sum = ones_sum(msg_sum, {pair_high, b});
      end
      msg_bytes = msg_bytes + 11'd1;
    end else begin
      msg_bytes = 11'(icmpd_pkg::MAX_MESSAGE_BYTES + 1);
    end
    if (last) begin
      if (msg_bytes < icmpd_pkg::HEADER_BYTES) begin
        r.status = icmpd_pkg::ST_TOO_SHORT;
      end else if (msg_bytes > icmpd_pkg::MAX_MESSAGE_BYTES) begin
        r.status = icmpd_pkg::ST_TOO_LONG;
      end else begin
        s = msg_sum;
        if (msg_bytes[0]) s = ones_sum(s, {pair_high, 8'h00});
        hdr_commit     = hdr_capture;
        payload_commit = payload_capture;
        r.status       = (~s == msg_checksum) ? icmpd_pkg::ST_OK : icmpd_pkg::ST_MISMATCH;
      end
      r.header  = hdr_commit;
      r.payload = payload_commit;
      results_due.insert(results_due.size(), r);
      msg_bytes = '0;
    end
  endtask

  task automatic queue_message(input int len, input fill_t fill, input bit good_sum);
    logic [7:0] body[];
    logic [15:0] s;
    byte_item_t it;
    body = new[len];
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: body[i] = 8'h00;
        FILL_ONES: body[i] = 8'hff;
        default:   body[i] = 8'($urandom_range(0, 255));
      endcase
    end
    if (good_sum && len >= 4) begin
      s = '0;
      for (int i = 0; i < len; i += 2) begin
        if (i != 2) s = ones_sum(s, {body[i], (i + 1 < len) ? body[i + 1] : 8'h00});
      end
      body[2] = ~s[15:8];
      body[3] = ~s[7:0];
    end
    for (int i = 0; i < len; i++) begin
      it.data  = body[i];
      it.last  = (i == len - 1);
      it.pause = 1'b0;
      pending_bytes.insert(pending_bytes.size(), it);
    end
  endtask

  task automatic queue_pause();
    byte_item_t it;
    it.data  = 8'h00;
    it.last  = 1'b0;
    it.pause = 1'b1;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_last_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && pending_bytes[0].pause) begin
          in_valid <= 1'b0;
          if (results_due.size() == 0) void'(pending_bytes.pop_front());
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= next_byte.data;
          in_last_byte <= next_byte.last;
          if (pending_bytes.size() > CALM_ITEMS && $urandom_range(0, 15) == 0)
            send_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    icmpd_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result item", 64'(out_status), 64'd0);
        end else begin
          want = results_due.pop_front();
          if (out_status != want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_msg_type != want.header.msg_type)
            report_mismatch("msg_type", 64'(out_msg_type), 64'(want.header.msg_type));
          if (out_msg_code != want.header.msg_code)
            report_mismatch("msg_code", 64'(out_msg_code), 64'(want.header.msg_code));
          if (out_identifier != want.header.identifier)
            report_mismatch("identifier", 64'(out_identifier),
                            64'(want.header.identifier));
          if (out_sequence_res != want.header.sequence_res)
            report_mismatch("sequence_res", 64'(out_sequence_res),
                            64'(want.header.sequence_res));
          if (out_payload_value != want.payload)
            report_mismatch("payload_value", out_payload_value, want.payload);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (pending_bytes.size() > CALM_ITEMS && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 18);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int    pick;
    int    len;
    int    msgs;
    fill_t fill;
    msg_bytes           = '0;
    msg_sum             = '0;
    pair_high           = '0;
    msg_checksum        = '0;
    hdr_capture         = '0;
    payload_capture     = '0;
    hdr_commit          = '0;
    hdr_commit.msg_type = icmpd_pkg::RESET_MSG_TYPE;
    payload_commit      = '0;

    queue_message(1, FILL_ONES, 1'b0);
    queue_message(3, FILL_RANDOM, 1'b0);
    queue_message(8, FILL_ZERO, 1'b1);
    queue_message(8, FILL_ONES, 1'b0);
    queue_message(9, FILL_ONES, 1'b1);
    queue_pause();

    queue_message(icmpd_pkg::MAX_MESSAGE_BYTES + 1 + $urandom_range(0, 3),
                  FILL_RANDOM, 1'b1);
    queue_pause();

    msgs = 0;
    while (pending_bytes.size() < BYTE_BUDGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) len = $urandom_range(1, 7);
      else if (pick < 70) len = $urandom_range(8, 16);
      else len = $urandom_range(17, 40);
      pick = $urandom_range(0, 99);
      if (pick < 5) fill = FILL_ZERO;
      else if (pick < 10) fill = FILL_ONES;
      else fill = FILL_RANDOM;
      queue_message(len, fill, $urandom_range(0, 99) < 80);
      msgs++;
      if (msgs == 30) queue_pause();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
